// ===== sv/oversampled_soft_uart_core_defines.svh =====
// Assertion macros shared by the UART core.
`ifndef OVERSAMPLED_SOFT_UART_CORE_DEFINES_SVH
`define OVERSAMPLED_SOFT_UART_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled in reset
`define OSU_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("osu assertion failed");

// Next-cycle implication, disabled in reset
`define OSU_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("osu assertion failed");

`else

`define OSU_ASSERT_IMPL(label, clk, rst, ante, cons)
`define OSU_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== sv/osu_pkg.sv =====
`timescale 1ns / 1ps

package osu_pkg;

  // One oversampling tick as seen on the input channel
  typedef struct packed {
    logic       rx_line;
    logic       rx_room;
    logic       tx_push;
    logic [7:0] tx_byte;
  } in_item_t;

  // One result per tick
  typedef struct packed {
    logic       tx_line;
    logic       rx_valid;
    logic [7:0] rx_data;
    logic       rx_busy;
    logic       tx_busy;
    logic       tx_dropped;
  } out_item_t;

  // Receiver step result
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       busy;
  } rx_res_t;

  // Transmitter step result
  typedef struct packed {
    logic line;
    logic busy;
    logic dropped;
  } tx_res_t;

  // Register decode (paddr[2])
  localparam logic REG_RX_TICKS = 1'b0;
  localparam logic REG_TX_TICKS = 1'b1;

  localparam logic [7:0] TICKS_RESET = 8'd3;

  // Receiver phases: idle, start wait / data bits, stop wait
  localparam logic [3:0] RX_PH_IDLE  = 4'd0;
  localparam logic [3:0] RX_PH_FIRST = 4'd1;
  localparam logic [3:0] RX_PH_STOP  = 4'd9;

  // Transmitter phases: 10 start, 9..2 data, 1 stop, 0 idle
  localparam logic [3:0] TX_PH_IDLE      = 4'd0;
  localparam logic [3:0] TX_PH_STOP      = 4'd1;
  localparam logic [3:0] TX_PH_DATA_LAST = 4'd2;
  localparam logic [3:0] TX_PH_DATA_MAX  = 4'd9;
  localparam logic [3:0] TX_PH_START     = 4'd10;

endpackage

// ===== sv/osu_ram.sv =====
`timescale 1ns / 1ps

module osu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, write-first on a same-address collision
  always_ff @(posedge clk) begin
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/osu_rx.sv =====
`timescale 1ns / 1ps

module osu_rx import osu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       adv,
  input  logic       line,
  input  logic       room,
  input  logic [7:0] ticks,
  output rx_res_t    res
);

  logic [3:0] phase, phase_next;
  logic [7:0] shift, shift_next;
  logic [8:0] timer, timer_next;
  logic       active, active_next;
  logic [7:0] sampled;

  // Frame timing and bit sampling
  always_comb begin
    phase_next  = phase;
    shift_next  = shift;
    timer_next  = timer;
    active_next = active;
    sampled     = {line, shift[6:0]};
    res.valid   = 1'b0;
    res.data    = 8'd0;
    if (room) begin
      if (phase != RX_PH_IDLE) begin
        if (timer <= 9'd1) begin
          if (phase >= RX_PH_STOP) begin
            // stop period over, stop bit not checked
            res.valid   = 1'b1;
            res.data    = shift;
            shift_next  = 8'd0;
            phase_next  = RX_PH_IDLE;
            timer_next  = 9'd0;
            active_next = 1'b0;
          end else begin
            timer_next = {1'b0, ticks};
            phase_next = phase + 4'd1;
            shift_next = (phase_next != RX_PH_STOP) ? (sampled >> 1) : sampled;
          end
        end else begin
          timer_next = timer - 9'd1;
        end
      end else if (!line) begin
        // start edge: wait one and a bit periods
        phase_next  = RX_PH_FIRST;
        timer_next  = {1'b0, ticks} + 9'd1;
        active_next = 1'b1;
      end
    end
    res.busy = active_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= RX_PH_IDLE;
      shift  <= 8'd0;
      timer  <= 9'd0;
      active <= 1'b0;
    end else if (adv) begin
      phase  <= phase_next;
      shift  <= shift_next;
      timer  <= timer_next;
      active <= active_next;
    end
  end

endmodule

// ===== sv/osu_tx.sv =====
`timescale 1ns / 1ps

module osu_tx import osu_pkg::*; #(
  parameter int TX_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       adv,
  input  logic       push,
  input  logic [7:0] byte_in,
  input  logic [7:0] ticks,
  output tx_res_t    res
);

  localparam int AW = $clog2(TX_DEPTH);
  localparam int CW = $clog2(TX_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(TX_DEPTH);
  localparam logic [AW-1:0] LAST = AW'(TX_DEPTH - 1);

  logic [AW-1:0] head, head_next, tail, tail_next, raddr;
  logic [CW-1:0] count, count_next, count_after;
  logic [3:0]    phase, phase_next;
  logic [7:0]    shift, shift_next;
  logic [7:0]    timer, timer_next;
  logic          level, level_next;
  logic          active, active_next;
  logic          push_ok, pop;
  logic [7:0]    head_data, pop_byte;

  // FIFO storage; head entry is prefetched every cycle
  osu_ram #(
    .WIDTH(8),
    .DEPTH(TX_DEPTH)
  ) u_queue (
    .clk  (clk),
    .we   (adv && push_ok),
    .waddr(tail),
    .wdata(byte_in),
    .raddr(raddr),
    .rdata(head_data)
  );

  // Push is judged against the level before any pop
  assign push_ok     = push && (count != FULL);
  assign count_after = count + CW'(push_ok);
  assign pop_byte    = (count == '0) ? byte_in : head_data;

  // Frame sequencer
  always_comb begin
    phase_next  = phase;
    shift_next  = shift;
    timer_next  = timer;
    level_next  = level;
    active_next = active;
    pop         = 1'b0;
    if (phase != TX_PH_IDLE) begin
      if (timer <= 8'd1) begin
        timer_next = ticks;
        if (phase == TX_PH_START) begin
          level_next = 1'b0;
          phase_next = TX_PH_DATA_MAX;
        end else if (phase >= TX_PH_DATA_LAST && phase <= TX_PH_DATA_MAX) begin
          level_next = shift[0];
          shift_next = shift >> 1;
          phase_next = phase - 4'd1;
        end else begin
          // stop bit, then next frame or idle
          level_next = 1'b1;
          if (count_after != '0) begin
            pop        = 1'b1;
            shift_next = pop_byte;
            phase_next = TX_PH_START;
          end else begin
            phase_next  = TX_PH_IDLE;
            active_next = 1'b0;
          end
        end
      end else begin
        timer_next = timer - 8'd1;
      end
    end else if (count_after != '0) begin
      pop         = 1'b1;
      shift_next  = pop_byte;
      phase_next  = TX_PH_START;
      timer_next  = ticks;
      active_next = 1'b1;
    end
  end

  // Pointer and level update
  always_comb begin
    tail_next  = push_ok ? ((tail == LAST) ? '0 : tail + 1'b1) : tail;
    head_next  = pop ? ((head == LAST) ? '0 : head + 1'b1) : head;
    count_next = count_after - CW'(pop);
    raddr      = adv ? head_next : head;
  end

  assign res.line    = level_next;
  assign res.busy    = active_next;
  assign res.dropped = push && !push_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      head   <= '0;
      tail   <= '0;
      count  <= '0;
      phase  <= TX_PH_IDLE;
      shift  <= 8'd0;
      timer  <= 8'd0;
      level  <= 1'b1;
      active <= 1'b0;
    end else if (adv) begin
      head   <= head_next;
      tail   <= tail_next;
      count  <= count_next;
      phase  <= phase_next;
      shift  <= shift_next;
      timer  <= timer_next;
      level  <= level_next;
      active <= active_next;
    end
  end

endmodule

// ===== sv/oversampled_soft_uart_core.sv =====
// Oversampled 8N1 UART, one channel. Each input transfer is one oversampling
// tick and yields exactly one output transfer with the line level, the received
// byte strobe and the busy/drop flags after that tick. The core takes one tick
// per clock cycle while the output is not stalled; a tick's result is registered
// in the input register, then in the result register, and a stalled output holds
// the pipeline. The transmit queue is a TX_DEPTH-entry RAM whose head entry is
// prefetched so a pop completes in the same tick. Tick-per-bit registers sit
// on the APB port at 0x0 (receive) and 0x4 (transmit), reset value 3.
`timescale 1ns / 1ps
`include "oversampled_soft_uart_core_defines.svh"

module oversampled_soft_uart_core import osu_pkg::*; #(
  parameter int TX_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic     in_reg_valid;
  in_item_t in_reg;
  logic     adv;
  logic     cfg_we;
  logic [7:0] rx_ticks, tx_ticks;
  rx_res_t  rx_res;
  tx_res_t  tx_res;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_ticks <= TICKS_RESET;
      tx_ticks <= TICKS_RESET;
    end else if (cfg_we) begin
      unique case (paddr[2])
        REG_RX_TICKS: rx_ticks <= pwdata[7:0];
        REG_TX_TICKS: tx_ticks <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_RX_TICKS: prdata = {24'd0, rx_ticks};
      REG_TX_TICKS: prdata = {24'd0, tx_ticks};
      default:      prdata = 32'd0;
    endcase
  end

  // Input register; a tick advances when the result register can take it
  assign adv      = in_reg_valid && (!out_valid || out_ready);
  assign in_ready = !in_reg_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else begin
      in_reg_valid <= (in_valid && in_ready) || (in_reg_valid && !adv);
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_reg <= in_data;
    end
  end

  osu_rx u_rx (
    .clk  (clk),
    .rst  (rst),
    .adv  (adv),
    .line (in_reg.rx_line),
    .room (in_reg.rx_room),
    .ticks(rx_ticks),
    .res  (rx_res)
  );

  osu_tx #(
    .TX_DEPTH(TX_DEPTH)
  ) u_tx (
    .clk    (clk),
    .rst    (rst),
    .adv    (adv),
    .push   (in_reg.tx_push),
    .byte_in(in_reg.tx_byte),
    .ticks  (tx_ticks),
    .res    (tx_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= adv || (out_valid && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.tx_line    <= tx_res.line;
      out_data.rx_valid   <= rx_res.valid;
      out_data.rx_data    <= rx_res.data;
      out_data.rx_busy    <= rx_res.busy;
      out_data.tx_busy    <= tx_res.busy;
      out_data.tx_dropped <= tx_res.dropped;
    end
  end

  // Checks
  `OSU_ASSERT_IMPL(a_ready_when_out_free, clk, rst, !out_valid, in_ready)
  `OSU_ASSERT_NEXT(a_tick_reaches_out, clk, rst, in_reg_valid && out_ready, out_valid)
  `OSU_ASSERT_IMPL(a_rx_done_not_busy, clk, rst, out_valid && out_data.rx_valid, !out_data.rx_busy)
  `OSU_ASSERT_IMPL(a_rx_data_zero, clk, rst, out_valid && !out_data.rx_valid, out_data.rx_data == 8'd0)

endmodule
